FILE: rtl/core/hsb_pkg.sv
`timescale 1ns / 1ps

package hsb_pkg;

    localparam int NUM_BINS    = 256;
    localparam int COUNT_BITS  = 32;
    localparam int BIN_BITS    = $clog2(NUM_BINS);
    localparam int OP_BITS     = 2;
    localparam int PIXEL_BITS  = 8;
    localparam int HEIGHT_BITS = 10;
    localparam int OUT_BITS    = 32;
    localparam int CMP_BITS    = ((BIN_BITS > PIXEL_BITS) ? BIN_BITS : PIXEL_BITS) + 1;
    localparam int NUM_BITS    = COUNT_BITS + HEIGHT_BITS;
    localparam int SAT_BITS    = (COUNT_BITS > OUT_BITS) ? COUNT_BITS : OUT_BITS;
    localparam int STEP_BITS   = $clog2(HEIGHT_BITS);
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_BITS   = $clog2(QUEUE_DEPTH);
    localparam int QCNT_BITS   = $clog2(QUEUE_DEPTH + 1);

    localparam logic [HEIGHT_BITS-1:0] FULL_SCALE_RESET = HEIGHT_BITS'(280);
    localparam logic [COUNT_BITS-1:0]  COUNT_MAX        = '1;
    localparam logic [SAT_BITS-1:0]    OUT_MAX          = SAT_BITS'({OUT_BITS{1'b1}});

    localparam logic [OP_BITS-1:0] OP_CLEAR = 2'd0;
    localparam logic [OP_BITS-1:0] OP_ADD   = 2'd1;
    localparam logic [OP_BITS-1:0] OP_READ  = 2'd2;

    // One pending read handed from the front end to the scaling unit.
    typedef struct packed {
        logic [COUNT_BITS-1:0] count;
        logic [COUNT_BITS-1:0] peak;
    } read_job_t;

    function automatic logic [OUT_BITS-1:0] sat_out(input logic [COUNT_BITS-1:0] v);
        logic [SAT_BITS-1:0] w;
        w = SAT_BITS'(v);
        if (w > OUT_MAX)
        begin
            return {OUT_BITS{1'b1}};
        end
        return OUT_BITS'(w);
    endfunction

endpackage

FILE: rtl/core/hsb_in_if.sv
`timescale 1ns / 1ps

interface hsb_in_if;
    logic                            valid;
    logic                            ready;
    logic [hsb_pkg::OP_BITS-1:0]     operation;
    logic [hsb_pkg::PIXEL_BITS-1:0]  pixel_value;
    logic [hsb_pkg::PIXEL_BITS-1:0]  query_bin;

    modport source (output valid, output operation, output pixel_value, output query_bin,
                    input ready);
    modport sink   (input valid, input operation, input pixel_value, input query_bin,
                    output ready);
endinterface

FILE: rtl/core/hsb_out_if.sv
`timescale 1ns / 1ps

interface hsb_out_if;
    logic                             valid;
    logic                             ready;
    logic [hsb_pkg::HEIGHT_BITS-1:0]  bar_height;
    logic [hsb_pkg::OUT_BITS-1:0]     raw_count;
    logic [hsb_pkg::OUT_BITS-1:0]     peak_value;

    modport source (output valid, output bar_height, output raw_count, output peak_value,
                    input ready);
    modport sink   (input valid, input bar_height, input raw_count, input peak_value,
                    output ready);
endinterface

FILE: rtl/core/hsb_ram.sv
`timescale 1ns / 1ps

module hsb_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/core/hsb_front.sv
`timescale 1ns / 1ps

module hsb_front (
    input  logic               clk,
    input  logic               rst_n,
    hsb_in_if.sink             req,
    output logic               push,
    output hsb_pkg::read_job_t job,
    input  logic               q_full
);

    logic                               s1_valid_reg;
    logic [hsb_pkg::OP_BITS-1:0]        s1_op_reg;
    logic [hsb_pkg::BIN_BITS-1:0]       s1_addr_reg;
    logic                               s1_in_range_reg;
    logic [hsb_pkg::NUM_BINS-1:0]       bin_valid_reg;
    logic [hsb_pkg::NUM_BINS-1:0]       bin_valid_next;
    logic [hsb_pkg::COUNT_BITS-1:0]     peak_reg;
    logic [hsb_pkg::COUNT_BITS-1:0]     peak_next;
    logic                               last_wr_valid_reg;
    logic [hsb_pkg::BIN_BITS-1:0]       last_wr_addr_reg;
    logic [hsb_pkg::COUNT_BITS-1:0]     last_wr_data_reg;

    logic                               stall;
    logic                               accept;
    logic                               s1_fire;
    logic [hsb_pkg::PIXEL_BITS-1:0]     sel_value;
    logic                               in_range;
    logic [hsb_pkg::COUNT_BITS-1:0]     ram_rdata;
    logic [hsb_pkg::COUNT_BITS-1:0]     stored;
    logic [hsb_pkg::COUNT_BITS-1:0]     cur_count;
    logic [hsb_pkg::COUNT_BITS-1:0]     new_count;
    logic                               wr_en;
    logic                               clr;

    assign stall     = s1_valid_reg && (s1_op_reg == hsb_pkg::OP_READ) && q_full;
    assign req.ready = !stall;
    assign accept    = req.valid && req.ready;
    assign s1_fire   = s1_valid_reg && !stall;

    assign sel_value = (req.operation == hsb_pkg::OP_READ) ? req.query_bin : req.pixel_value;
    assign in_range  = hsb_pkg::CMP_BITS'(sel_value) < hsb_pkg::CMP_BITS'(hsb_pkg::NUM_BINS);

    hsb_ram #(
        .WIDTH (hsb_pkg::COUNT_BITS),
        .DEPTH (hsb_pkg::NUM_BINS)
    ) u_bins (
        .clk   (clk),
        .we    (wr_en),
        .waddr (s1_addr_reg),
        .wdata (new_count),
        .re    (accept),
        .raddr (hsb_pkg::BIN_BITS'(sel_value)),
        .rdata (ram_rdata)
    );

    // The RAM read was launched at the same edge as the previous write, so the
    // most recent write is forwarded when it hits the same bin.
    assign stored    = (last_wr_valid_reg && (last_wr_addr_reg == s1_addr_reg))
                       ? last_wr_data_reg : ram_rdata;
    assign cur_count = bin_valid_reg[s1_addr_reg] ? stored : '0;
    assign new_count = (cur_count == hsb_pkg::COUNT_MAX)
                       ? cur_count : cur_count + hsb_pkg::COUNT_BITS'(1);

    assign wr_en = s1_fire && (s1_op_reg == hsb_pkg::OP_ADD) && s1_in_range_reg;
    assign clr   = s1_fire && (s1_op_reg == hsb_pkg::OP_CLEAR);
    assign push  = s1_fire && (s1_op_reg == hsb_pkg::OP_READ);

    assign job.count = s1_in_range_reg ? cur_count : '0;
    assign job.peak  = s1_in_range_reg ? peak_reg : '0;

    always_comb
    begin
        bin_valid_next = bin_valid_reg;
        peak_next      = peak_reg;
        if (clr)
        begin
            bin_valid_next = '0;
            peak_next      = '0;
        end
        else if (wr_en)
        begin
            bin_valid_next[s1_addr_reg] = 1'b1;
            if (new_count > peak_reg)
            begin
                peak_next = new_count;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg      <= 1'b0;
            bin_valid_reg     <= '0;
            peak_reg          <= '0;
            last_wr_valid_reg <= 1'b0;
        end
        else
        begin
            if (!stall)
            begin
                s1_valid_reg <= accept;
            end
            bin_valid_reg <= bin_valid_next;
            peak_reg      <= peak_next;
            if (wr_en)
            begin
                last_wr_valid_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_op_reg       <= req.operation;
            s1_addr_reg     <= hsb_pkg::BIN_BITS'(sel_value);
            s1_in_range_reg <= in_range;
        end
        if (wr_en)
        begin
            last_wr_addr_reg <= s1_addr_reg;
            last_wr_data_reg <= new_count;
        end
    end

endmodule

FILE: rtl/core/hsb_queue.sv
`timescale 1ns / 1ps

module hsb_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  hsb_pkg::read_job_t push_job,
    input  logic               pop,
    output hsb_pkg::read_job_t head,
    output logic               empty,
    output logic               full
);

    hsb_pkg::read_job_t              entry_reg [hsb_pkg::QUEUE_DEPTH];
    logic [hsb_pkg::QPTR_BITS-1:0]   wr_ptr_reg;
    logic [hsb_pkg::QPTR_BITS-1:0]   rd_ptr_reg;
    logic [hsb_pkg::QCNT_BITS-1:0]   cnt_reg;
    logic [hsb_pkg::QCNT_BITS-1:0]   cnt_next;
    logic                            do_push;
    logic                            do_pop;

    assign empty   = (cnt_reg == '0);
    assign full    = (cnt_reg == hsb_pkg::QCNT_BITS'(hsb_pkg::QUEUE_DEPTH));
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;
    assign head    = entry_reg[rd_ptr_reg];

    function automatic logic [hsb_pkg::QPTR_BITS-1:0] wrap_inc(
        input logic [hsb_pkg::QPTR_BITS-1:0] p);
        if (p == hsb_pkg::QPTR_BITS'(hsb_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + hsb_pkg::QPTR_BITS'(1);
    endfunction

    always_comb
    begin
        cnt_next = cnt_reg;
        if (do_push && !do_pop)
        begin
            cnt_next = cnt_reg + hsb_pkg::QCNT_BITS'(1);
        end
        else if (do_pop && !do_push)
        begin
            cnt_next = cnt_reg - hsb_pkg::QCNT_BITS'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            cnt_reg <= cnt_next;
            if (do_push)
            begin
                wr_ptr_reg <= wrap_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= wrap_inc(rd_ptr_reg);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            entry_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

FILE: rtl/core/hsb_back.sv
`timescale 1ns / 1ps

module hsb_back (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic [hsb_pkg::HEIGHT_BITS-1:0]  fs,
    input  hsb_pkg::read_job_t               head,
    input  logic                             empty,
    output logic                             pop,
    hsb_out_if.source                        rsp
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_MUL  = 4'b0010,
        ST_DIV  = 4'b0100,
        ST_HOLD = 4'b1000
    } back_state_t;

    back_state_t                         state_reg;
    back_state_t                         state_next;
    logic [hsb_pkg::COUNT_BITS-1:0]      count_reg;
    logic [hsb_pkg::COUNT_BITS-1:0]      peak_reg;
    logic [hsb_pkg::COUNT_BITS-1:0]      rem_reg;
    logic [hsb_pkg::COUNT_BITS-1:0]      rem_next;
    logic [hsb_pkg::HEIGHT_BITS-1:0]     low_reg;
    logic [hsb_pkg::HEIGHT_BITS-1:0]     low_next;
    logic [hsb_pkg::STEP_BITS-1:0]       step_reg;
    logic [hsb_pkg::STEP_BITS-1:0]       step_next;
    logic [hsb_pkg::HEIGHT_BITS-1:0]     bar_reg;
    logic [hsb_pkg::HEIGHT_BITS-1:0]     bar_next;
    logic [hsb_pkg::OUT_BITS-1:0]        raw_reg;
    logic [hsb_pkg::OUT_BITS-1:0]        pk_reg;

    logic [hsb_pkg::NUM_BITS-1:0]        num;
    logic [hsb_pkg::COUNT_BITS:0]        trial;
    logic [hsb_pkg::COUNT_BITS:0]        diff;
    logic                                ge;
    logic                                last_step;
    logic                                finish;

    assign pop = !empty && ((state_reg == ST_IDLE) || ((state_reg == ST_HOLD) && rsp.ready));

    // Rounded-up numerator; the quotient never exceeds the full scale, so it
    // fits in HEIGHT_BITS and the top part of the numerator starts below peak.
    assign num = hsb_pkg::NUM_BITS'(count_reg) * hsb_pkg::NUM_BITS'(fs)
                 + hsb_pkg::NUM_BITS'(peak_reg) - hsb_pkg::NUM_BITS'(1);

    assign trial     = {rem_reg, low_reg[hsb_pkg::HEIGHT_BITS-1]};
    assign diff      = trial - {1'b0, peak_reg};
    assign ge        = (trial >= {1'b0, peak_reg});
    assign last_step = (step_reg == hsb_pkg::STEP_BITS'(hsb_pkg::HEIGHT_BITS - 1));
    assign finish    = (state_reg == ST_DIV) && last_step;

    always_comb
    begin
        state_next = state_reg;
        rem_next   = rem_reg;
        low_next   = low_reg;
        step_next  = step_reg;
        bar_next   = bar_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (pop)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                rem_next   = num[hsb_pkg::NUM_BITS-1:hsb_pkg::HEIGHT_BITS];
                low_next   = num[hsb_pkg::HEIGHT_BITS-1:0];
                step_next  = '0;
                state_next = ST_DIV;
            end
            ST_DIV:
            begin
                rem_next  = ge ? diff[hsb_pkg::COUNT_BITS-1:0] : trial[hsb_pkg::COUNT_BITS-1:0];
                low_next  = {low_reg[hsb_pkg::HEIGHT_BITS-2:0], ge};
                step_next = step_reg + hsb_pkg::STEP_BITS'(1);
                if (last_step)
                begin
                    bar_next   = (peak_reg == '0) ? '0 : low_next;
                    state_next = ST_HOLD;
                end
            end
            ST_HOLD:
            begin
                if (rsp.ready)
                begin
                    state_next = pop ? ST_MUL : ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            count_reg <= head.count;
            peak_reg  <= head.peak;
        end
        if (finish)
        begin
            raw_reg <= hsb_pkg::sat_out(count_reg);
            pk_reg  <= hsb_pkg::sat_out(peak_reg);
        end
        rem_reg  <= rem_next;
        low_reg  <= low_next;
        step_reg <= step_next;
        bar_reg  <= bar_next;
    end

    assign rsp.valid      = (state_reg == ST_HOLD);
    assign rsp.bar_height = bar_reg;
    assign rsp.raw_count  = raw_reg;
    assign rsp.peak_value = pk_reg;

endmodule

FILE: rtl/core/histogram_with_scaled_bars.sv
`timescale 1ns / 1ps
// Clear and add items are taken one per cycle unless a read waiting on a full queue
// stalls the front end; the counter read-modify-write resolves in the cycle after
// acceptance, with forwarding between neighbors. A read item passes through the
// front-end stage and the read queue to the shared scaling unit (a multiply state,
// ten restoring divide steps, an output hold state), which serves one read at a time.
// Reset clears bin valid marks, peak, queue and control; full scale returns to 280.

module histogram_with_scaled_bars (
    input  logic                             clk,
    input  logic                             rst_n,
    input  logic                             cfg_wr_en,
    input  logic [hsb_pkg::HEIGHT_BITS-1:0]  cfg_wr_data,
    hsb_in_if.sink                           req,
    hsb_out_if.source                        rsp
);

    logic [hsb_pkg::HEIGHT_BITS-1:0]  fs_reg;
    logic                             q_push;
    logic                             q_pop;
    logic                             q_empty;
    logic                             q_full;
    hsb_pkg::read_job_t               push_job;
    hsb_pkg::read_job_t               head_job;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fs_reg <= hsb_pkg::FULL_SCALE_RESET;
        end
        else if (cfg_wr_en)
        begin
            fs_reg <= cfg_wr_data;
        end
    end

    hsb_front u_front (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (req),
        .push   (q_push),
        .job    (push_job),
        .q_full (q_full)
    );

    hsb_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (q_push),
        .push_job (push_job),
        .pop      (q_pop),
        .head     (head_job),
        .empty    (q_empty),
        .full     (q_full)
    );

    hsb_back u_back (
        .clk   (clk),
        .rst_n (rst_n),
        .fs    (fs_reg),
        .head  (head_job),
        .empty (q_empty),
        .pop   (q_pop),
        .rsp   (rsp)
    );

    // The front end must hold a read back while the queue is full.
    a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_push && q_full))
        else $error("read pushed into a full queue");

    a_bar_within_scale: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.bar_height <= fs_reg))
        else $error("bar height above full scale");

    a_count_within_peak: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid |-> (rsp.raw_count <= rsp.peak_value))
        else $error("bin count above peak");

endmodule

FILE: test/hsb_read_checker.sv
`timescale 1ns / 1ps

module hsb_read_checker (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_wr_en,
    input  logic [hsb_pkg::HEIGHT_BITS-1:0] cfg_wr_data,
    hsb_in_if                               req,
    hsb_out_if                              rsp,
    output int                              mismatches,
    output int                              pending_reads,
    output int                              reads_checked
);
    import hsb_pkg::*;

    typedef struct packed {
        logic [HEIGHT_BITS-1:0] height;
        logic [OUT_BITS-1:0]    raw;
        logic [OUT_BITS-1:0]    peak;
    } bar_result_t;

    logic [COUNT_BITS-1:0]  bin_count [NUM_BINS];
    logic                   bin_live  [NUM_BINS];
    logic [COUNT_BITS-1:0]  peak_count;
    logic [HEIGHT_BITS-1:0] full_scale;
    bar_result_t            bars_due [$];

    task automatic log_fault(input string msg);
        mismatches++;
        if (mismatches <= 10)
        begin
            $display("%0t ns: %s", $realtime, msg);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin : predict_and_check
        bar_result_t           due;
        logic [COUNT_BITS-1:0] c;
        logic [63:0]           scaled;
        int                    i;
        if (!rst_n)
        begin
            for (i = 0; i < NUM_BINS; i++)
            begin
                bin_live[i] = 1'b0;
                bin_count[i] = '0;
            end
            peak_count = '0;
            full_scale = FULL_SCALE_RESET;
            bars_due.delete();
            mismatches = 0;
            pending_reads = 0;
            reads_checked = 0;
        end
        else
        begin
            // Results leaving this edge belong to reads accepted earlier, so
            // they are matched before the incoming item is applied.
            if (rsp.valid && rsp.ready)
            begin
                if (bars_due.size() == 0)
                begin
                    log_fault($sformatf("result with no read pending: height %0d count %0d peak %0d",
                                        rsp.bar_height, rsp.raw_count, rsp.peak_value));
                end
                else
                begin
                    due = bars_due.pop_front();
                    reads_checked++;
                    if (rsp.bar_height !== due.height)
                    begin
                        log_fault($sformatf("bar_height expected %0d, got %0d",
                                            due.height, rsp.bar_height));
                    end
                    if (rsp.raw_count !== due.raw)
                    begin
                        log_fault($sformatf("raw_count expected %0d, got %0d",
                                            due.raw, rsp.raw_count));
                    end
                    if (rsp.peak_value !== due.peak)
                    begin
                        log_fault($sformatf("peak_value expected %0d, got %0d",
                                            due.peak, rsp.peak_value));
                    end
                end
            end

            if (req.valid && req.ready)
            begin
                case (req.operation)
                    OP_CLEAR:
                    begin
                        for (i = 0; i < NUM_BINS; i++)
                        begin
                            bin_live[i] = 1'b0;
                        end
                        peak_count = '0;
                    end
                    OP_ADD:
                    begin
                        c = bin_live[req.pixel_value] ? bin_count[req.pixel_value] : '0;
                        if (c != COUNT_MAX)
                        begin
                            c = c + COUNT_BITS'(1);
                        end
                        bin_count[req.pixel_value] = c;
                        bin_live[req.pixel_value] = 1'b1;
                        if (c > peak_count)
                        begin
                            peak_count = c;
                        end
                    end
                    OP_READ:
                    begin
                        c = bin_live[req.query_bin] ? bin_count[req.query_bin] : '0;
                        due.height = '0;
                        // An empty histogram has no peak to divide by.
                        if (peak_count != '0)
                        begin
                            scaled = (64'(c) * 64'(full_scale) + 64'(peak_count) - 64'd1)
                                     / 64'(peak_count);
                            due.height = scaled[HEIGHT_BITS-1:0];
                        end
                        due.raw = OUT_BITS'(c);
                        due.peak = OUT_BITS'(peak_count);
                        bars_due.push_back(due);
                    end
                    default:
                    begin
                    end
                endcase
            end

            if (cfg_wr_en)
            begin
                full_scale = cfg_wr_data;
            end
            pending_reads = bars_due.size();
        end
    end

endmodule

FILE: test/tb_histogram_with_scaled_bars.sv
`timescale 1ns / 1ps

module tb_histogram_with_scaled_bars;
    import hsb_pkg::*;

    localparam logic [OP_BITS-1:0] OP_UNUSED = 2'd3;
    localparam int ITEMS_PER_PHASE = 147;
    localparam int NUM_PHASES      = 7;
    localparam int HOLD_OFF_CYCLES = 400;
    localparam int SETTLE_CYCLES   = 20;
    localparam int DRAIN_LIMIT     = 50000;

    logic                   clk;
    logic                   rst_n;
    logic                   cfg_wr_en;
    logic [HEIGHT_BITS-1:0] cfg_wr_data;

    hsb_in_if  req_ch ();
    hsb_out_if rsp_ch ();

    int mismatches;
    int pending_reads;
    int reads_checked;
    int leftover;
    int op_seen [4] = '{default: 0};
    bit quiet_tail;
    bit hold_off_req;
    bit hold_off_done;

    histogram_with_scaled_bars dut (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .req         (req_ch),
        .rsp         (rsp_ch)
    );

    hsb_read_checker read_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_wr_data   (cfg_wr_data),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .mismatches    (mismatches),
        .pending_reads (pending_reads),
        .reads_checked (reads_checked)
    );

    always
    begin
        clk = 1'b0;
        #4;
        clk = 1'b1;
        #4;
    end

    task automatic send_item(input logic [OP_BITS-1:0]    op,
                             input logic [PIXEL_BITS-1:0] pix,
                             input logic [PIXEL_BITS-1:0] bin);
        req_ch.valid       <= 1'b1;
        req_ch.operation   <= op;
        req_ch.pixel_value <= pix;
        req_ch.query_bin   <= bin;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        op_seen[op]++;
    endtask

    // Sampling at the falling edge keeps the count clear of the checker's
    // update at the rising edge.
    task automatic wait_for_results();
        int waited;
        req_ch.valid <= 1'b0;
        waited = 0;
        do
        begin
            @(negedge clk);
            waited++;
        end
        while (pending_reads != 0 && waited < DRAIN_LIMIT);
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (pending_reads != 0)
        begin
            leftover += pending_reads;
        end
    endtask

    initial
    begin : rsp_ready_gen
        rsp_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_off_req && !hold_off_done)
            begin
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_OFF_CYCLES) @(posedge clk);
                hold_off_done = 1'b1;
            end
            else if (!quiet_tail && $urandom_range(0, 4) == 0)
            begin
                rsp_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 6) - 1) @(posedge clk);
            end
            else
            begin
                rsp_ch.ready <= 1'b1;
            end
        end
    end

    initial
    begin : stimulus
        int                     p;
        int                     k;
        int                     n;
        int                     roll;
        logic [OP_BITS-1:0]     op;
        logic [PIXEL_BITS-1:0]  pix;
        logic [PIXEL_BITS-1:0]  bin;
        logic [HEIGHT_BITS-1:0] scale;
        logic [PIXEL_BITS-1:0]  hot_bins [4];

        rst_n              <= 1'b0;
        cfg_wr_en          <= 1'b0;
        cfg_wr_data        <= '0;
        req_ch.valid       <= 1'b0;
        req_ch.operation   <= OP_CLEAR;
        req_ch.pixel_value <= '0;
        req_ch.query_bin   <= '0;
        quiet_tail    = 1'b0;
        hold_off_req  = 1'b0;
        hold_off_done = 1'b0;
        leftover      = 0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed items at the reset full scale: empty reads, edge bins,
        // a bin never written, the unused code, and reads around a clear.
        send_item(OP_READ, 8'd0, 8'd0);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_ADD, 8'd0, 8'd0);
        send_item(OP_ADD, 8'd255, 8'd0);
        send_item(OP_ADD, 8'd255, 8'd0);
        send_item(OP_ADD, 8'd128, 8'd0);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_READ, 8'd0, 8'd0);
        send_item(OP_READ, 8'd0, 8'd7);
        send_item(OP_UNUSED, 8'd7, 8'd7);
        send_item(OP_UNUSED, 8'hFF, 8'hFF);
        send_item(OP_READ, 8'd0, 8'd7);
        send_item(OP_CLEAR, 8'd0, 8'd0);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_ADD, 8'd255, 8'd0);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_ADD, 8'd0, 8'd0);
        send_item(OP_ADD, 8'd0, 8'd0);
        send_item(OP_ADD, 8'd0, 8'd0);
        send_item(OP_READ, 8'd0, 8'd255);
        send_item(OP_READ, 8'd0, 8'd0);
        send_item(OP_ADD, 8'hAA, 8'h55);
        send_item(OP_ADD, 8'h55, 8'hAA);
        send_item(OP_READ, 8'hAA, 8'h55);

        for (p = 0; p < NUM_PHASES; p++)
        begin
            wait_for_results();
            case (p)
                0: scale = 10'd1023;
                1: scale = 10'd1;
                3: scale = 10'd0;
                5: scale = 10'd512;
                default: scale = HEIGHT_BITS'($urandom_range(2, 1022));
            endcase
            cfg_wr_en   <= 1'b1;
            cfg_wr_data <= scale;
            @(posedge clk);
            cfg_wr_en <= 1'b0;

            for (k = 0; k < 4; k++)
            begin
                hot_bins[k] = PIXEL_BITS'($urandom);
            end
            hold_off_req = (p == 1);
            quiet_tail = (p == NUM_PHASES - 1);

            // Mostly adds into a few busy bins so counts and peaks grow,
            // with reads of busy and random bins and a rare clear.
            n = 0;
            while (n < ITEMS_PER_PHASE)
            begin
                if (!quiet_tail && $urandom_range(0, 4) == 0)
                begin
                    req_ch.valid <= 1'b0;
                    repeat ($urandom_range(1, 6)) @(posedge clk);
                end
                roll = $urandom_range(0, 99);
                if (roll < 1)
                begin
                    op = OP_CLEAR;
                end
                else if (roll < 6)
                begin
                    op = OP_UNUSED;
                end
                else if (roll < 34)
                begin
                    op = OP_READ;
                end
                else
                begin
                    op = OP_ADD;
                end
                pix = ($urandom_range(0, 9) < 6) ? hot_bins[$urandom_range(0, 3)]
                                                 : PIXEL_BITS'($urandom);
                bin = ($urandom_range(0, 1) == 0) ? hot_bins[$urandom_range(0, 3)]
                                                  : PIXEL_BITS'($urandom);
                send_item(op, pix, bin);
                if (op != OP_UNUSED)
                begin
                    n++;
                end
            end
        end
        wait_for_results();

        $display("Checked %0d bar reads after %0d adds, %0d clears and %0d unused-code items,",
                 reads_checked, op_seen[OP_ADD], op_seen[OP_CLEAR], op_seen[OP_UNUSED]);
        $display("over %0d full-scale settings (0, 1, 512, 1023 among them) and a %0d-cycle stall.",
                 NUM_PHASES + 1, HOLD_OFF_CYCLES);
        if (mismatches == 0 && leftover == 0)
        begin
            $display("tb_histogram_with_scaled_bars: clean");
        end
        else
        begin
            $display("tb_histogram_with_scaled_bars: errors");
        end
        $finish;
    end

    initial
    begin : run_limit
        #2000000;
        $display("Run limit reached with %0d reads outstanding.", pending_reads);
        $display("tb_histogram_with_scaled_bars: errors");
        $finish;
    end

endmodule

FILE: histogram_with_scaled_bars.f
rtl/core/hsb_pkg.sv
rtl/core/hsb_in_if.sv
rtl/core/hsb_out_if.sv
rtl/core/hsb_ram.sv
rtl/core/hsb_front.sv
rtl/core/hsb_queue.sv
rtl/core/hsb_back.sv
rtl/core/histogram_with_scaled_bars.sv
test/hsb_read_checker.sv
test/tb_histogram_with_scaled_bars.sv
